// File: hdl/assert_macros.svh
// Assertion macros included by the mapper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk_i edge outside reset.
`define EWPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on a rising clk_i edge outside reset.
`define EWPM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define EWPM_ASSERT(lbl, prop, msg)
`define EWPM_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/ewpm_pkg.sv
// Types, constants and helpers shared by the EMS window page mapper.
package ewpm_pkg;

  localparam int NUM_WINDOWS = 4;
  localparam int WIN_W       = $clog2(NUM_WINDOWS);

  // Access modes
  localparam logic [1:0] MODE_IO_WR  = 2'd0;
  localparam logic [1:0] MODE_IO_RD  = 2'd1;
  localparam logic [1:0] MODE_MEM_RD = 2'd2;
  localparam logic [1:0] MODE_MEM_WR = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MEM_SIZE = 1'b0;
  localparam logic CFG_ALT      = 1'b1;

  // I/O ports
  localparam logic [15:0] PORT_TURBO = 16'h01F0;
  localparam logic [13:0] PORT_PAGE  = 14'h0208;
  localparam logic [13:0] PORT_CTRL  = 14'h0209;

  // Reset values
  localparam logic [11:0] MEM_SIZE_RST = 12'd640;
  localparam logic [7:0]  TURBO_RST    = 8'h80;
  localparam logic [7:0]  PAGE_RST     = 8'h7F;
  localparam logic [7:0]  CTRL_ON_RST  = 8'h80;
  localparam logic [7:0]  CTRL_OFF_RST = 8'h00;
  localparam logic [5:0]  WBASE_RST    = 6'h38;
  localparam logic [5:0]  WBASE_ORG    = 6'h30;
  localparam logic [3:0]  WBASE_MASK   = 4'hC;
  localparam logic [7:0]  UNCLAIMED    = 8'hFF;

  // Layout bases
  localparam logic [19:0] ALT_BASE = 20'h70000;
  localparam logic [19:0] STD_BASE = 20'h30000;
  localparam logic [7:0]  ALT_OFS  = 8'd64;
  localparam logic [8:0]  STD_OFS  = 9'd320;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic [7:0]  write_data;
    logic [19:0] mem_addr;
  } ewpm_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        turbo_on;
    logic        window_hit;
    logic [20:0] ram_addr;
    logic        ram_ok;
    logic        ram_write;
  } ewpm_out_t;

  // Configuration view
  typedef struct packed {
    logic [11:0] mem_size_kb;
    logic [19:0] ems_base;
    logic        ems_on;
  } ewpm_cfg_t;

  // Register file view for the item in flight
  typedef struct packed {
    logic [7:0] io_rdata;
    logic       turbo_on;
    logic [7:0] page;
    logic [5:0] wbase;
  } ewpm_view_t;

  // EMS base address for a memory size and layout
  function automatic logic [19:0] ems_base_f(logic [11:0] mem, logic alt);
    logic [7:0] a;
    logic [8:0] b;
    a = mem[7:0] + ALT_OFS;
    b = mem[8:0] + STD_OFS;
    return alt ? (ALT_BASE + {2'b00, a, 10'b0}) : (STD_BASE + {1'b0, b, 10'b0});
  endfunction

endpackage

// File: hdl/ewpm_cfg.sv
// Configuration registers: memory size, layout and the derived EMS base.
module ewpm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [11:0]         cfg_data_i,
  output ewpm_pkg::ewpm_cfg_t cfg_o
);
  import ewpm_pkg::*;

  logic [11:0] mem_size_q, mem_size_d;
  logic        alt_q, alt_d;
  logic [19:0] ems_base_q;

  // Select the written register
  always_comb begin
    mem_size_d = mem_size_q;
    alt_d      = alt_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MEM_SIZE: mem_size_d = cfg_data_i;
        CFG_ALT:      alt_d      = cfg_data_i[0];
        default:      mem_size_d = mem_size_q;
      endcase
    end
  end

  // Hold size and layout; rebuild the base along with every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MEM_SIZE_RST;
      alt_q      <= 1'b0;
      ems_base_q <= ems_base_f(MEM_SIZE_RST, 1'b0);
    end else if (cfg_we_i) begin
      mem_size_q <= mem_size_d;
      alt_q      <= alt_d;
      ems_base_q <= ems_base_f(mem_size_d, alt_d);
    end
  end

  assign cfg_o.mem_size_kb = mem_size_q;
  assign cfg_o.ems_base    = ems_base_q;
  assign cfg_o.ems_on      = (mem_size_q > MEM_SIZE_RST);

endmodule

// File: hdl/ewpm_regs.sv
// Turbo, page and control registers, window bases and port decode.
module ewpm_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  ewpm_pkg::ewpm_in_t   item_i,
  input  logic                 ems_on_i,
  output ewpm_pkg::ewpm_view_t view_o
);
  import ewpm_pkg::*;

  logic [7:0]                   turbo_q;
  logic [NUM_WINDOWS-1:0][7:0]  page_q;
  logic [NUM_WINDOWS-1:0][7:0]  ctrl_q;
  logic [NUM_WINDOWS-1:0][5:0]  wbase_q, wbase_d;
  logic [NUM_WINDOWS-1:0]       ctrl_bits;
  logic [WIN_W-1:0]             win;
  logic [WIN_W-1:0]             sel;
  logic                         is_io;
  logic                         is_turbo, is_page, is_ctrl;
  logic                         wr_turbo, wr_page, wr_ctrl;
  logic [3:0]                   rot;
  logic [7:0]                   io_rdata;

  // Decode the port
  assign win      = item_i.port[15:14];
  assign is_turbo = (item_i.port == PORT_TURBO);
  assign is_page  = ems_on_i && (item_i.port[13:0] == PORT_PAGE);
  assign is_ctrl  = ems_on_i && (item_i.port[13:0] == PORT_CTRL);
  assign wr_turbo = upd_i && (item_i.mode == MODE_IO_WR) && is_turbo;
  assign wr_page  = upd_i && (item_i.mode == MODE_IO_WR) && !is_turbo && is_page;
  assign wr_ctrl  = upd_i && (item_i.mode == MODE_IO_WR) && !is_turbo && !is_page && is_ctrl;

  // Rebuild the base index and move every window on a control write
  always_comb begin
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      ctrl_bits[i] = (WIN_W'(i) == win) ? item_i.write_data[7] : ctrl_q[i][7];
    end
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      rot        = ctrl_bits + 4'(NUM_WINDOWS - i);
      wbase_d[i] = WBASE_ORG + 6'(i) + {2'b00, rot & WBASE_MASK};
    end
  end

  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turbo_q <= TURBO_RST;
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        page_q[i]  <= PAGE_RST;
        ctrl_q[i]  <= (i == NUM_WINDOWS - 1) ? CTRL_OFF_RST : CTRL_ON_RST;
        wbase_q[i] <= WBASE_RST + 6'(i);
      end
    end else begin
      if (wr_turbo) begin
        turbo_q <= item_i.write_data;
      end
      if (wr_page) begin
        page_q[win] <= item_i.write_data;
      end
      if (wr_ctrl) begin
        ctrl_q[win] <= item_i.write_data;
        wbase_q     <= wbase_d;
      end
    end
  end

  // Pick one window for the item: port window for I/O, address window for memory
  assign is_io = (item_i.mode == MODE_IO_WR) || (item_i.mode == MODE_IO_RD);
  assign sel   = is_io ? win : item_i.mem_addr[15:14];

  // Drive the I/O read value
  always_comb begin
    if (is_turbo) begin
      io_rdata = turbo_q;
    end else if (is_page) begin
      io_rdata = page_q[sel];
    end else if (is_ctrl) begin
      io_rdata = ctrl_q[sel];
    end else begin
      io_rdata = UNCLAIMED;
    end
  end

  assign view_o.io_rdata = io_rdata;
  assign view_o.turbo_on = wr_turbo ? item_i.write_data[7] : turbo_q[7];
  assign view_o.page     = page_q[sel];
  assign view_o.wbase    = wbase_q[sel];

endmodule

// File: hdl/ewpm_xlate.sv
// Window match, EMS address translation and range check.
module ewpm_xlate (
  input  logic [19:0]          addr_i,
  input  logic [7:0]           page_i,
  input  logic [5:0]           wbase_i,
  input  ewpm_pkg::ewpm_cfg_t  cfg_i,
  output logic                 hit_o,
  output logic [20:0]          raddr_o,
  output logic                 ok_o
);
  import ewpm_pkg::*;

  logic [18:0] ofs;
  logic [21:0] limit;

  // Match the 16 KiB block against an enabled window
  assign hit_o = page_i[7] && (wbase_i == addr_i[19:14]);

  // Add page number, high bank bit and in-window offset to the EMS base
  assign ofs     = {page_i[6], page_i[3:0], addr_i[13:0]};
  assign raddr_o = {1'b0, cfg_i.ems_base} + {2'b00, ofs};

  // Check against installed memory
  assign limit = {cfg_i.mem_size_kb, 10'b0};
  assign ok_o  = hit_o && ({1'b0, raddr_o} < limit);

endmodule

// File: hdl/ems_window_page_mapper_unit.sv
// Top level of the EMS window page mapper: input stage, logic and result stage.
//
//   channel  direction  payload        handshake
//   in       sink       in_data_i      in_valid_i / in_stall_o
//   out      source     out_data_o     out_valid_o / out_stall_i
//   cfg      sink       cfg_data_i     cfg_we_i, cfg_idx_i
//
// One beat enters per cycle while in_stall_o is low.
// The beat is held in the input register while register updates, decode and
// address translation run; the result register then presents it downstream.
// Reset clears all mapper registers to their power-on values, empties both stages.
// A stalled output keeps its result; the input stage still takes one more beat.
module ems_window_page_mapper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ewpm_pkg::ewpm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ewpm_pkg::ewpm_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [11:0]         cfg_data_i
);
  import ewpm_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  ewpm_in_t   s1_q;
  logic       out_valid_q, out_valid_d;
  ewpm_out_t  out_q, res;
  logic       in_acc, s1_adv;
  ewpm_cfg_t  cfg;
  ewpm_view_t view;
  logic       hit, ok;
  logic [20:0] raddr;
  logic       is_mem;

  // Advance the input stage when the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  ewpm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ewpm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (s1_adv),
    .item_i   (s1_q),
    .ems_on_i (cfg.ems_on),
    .view_o   (view)
  );

  ewpm_xlate u_xlate (
    .addr_i  (s1_q.mem_addr),
    .page_i  (view.page),
    .wbase_i (view.wbase),
    .cfg_i   (cfg),
    .hit_o   (hit),
    .raddr_o (raddr),
    .ok_o    (ok)
  );

  // Assemble the result beat
  assign is_mem = (s1_q.mode == MODE_MEM_RD) || (s1_q.mode == MODE_MEM_WR);
  always_comb begin
    res            = '0;
    res.turbo_on   = view.turbo_on;
    if (s1_q.mode == MODE_IO_RD) begin
      res.read_data = view.io_rdata;
    end else if (is_mem) begin
      res.window_hit = hit;
      res.ram_addr   = hit ? raddr : {1'b0, s1_q.mem_addr};
      res.ram_ok     = ok;
      res.ram_write  = (s1_q.mode == MODE_MEM_WR) && ok;
      res.read_data  = ((s1_q.mode == MODE_MEM_RD) && hit && !ok) ? UNCLAIMED : 8'h00;
    end
  end

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  // Track stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "assert_macros.svh"

  `EWPM_ASSERT(a_stall_full, in_stall_o |-> (s1_valid_q && out_valid_q), "input stalled with room")
  `EWPM_ASSERT(a_adv_lands, s1_adv |=> out_valid_o, "advanced beat lost")
  `EWPM_NEVER(a_write_unchecked, out_valid_o && out_data_o.ram_write && !(out_data_o.window_hit && out_data_o.ram_ok), "write without hit and range")
  `EWPM_NEVER(a_ok_no_hit, out_valid_o && out_data_o.ram_ok && !out_data_o.window_hit, "range ok without hit")

endmodule
